[hdl/ppp_pkg.sv]
// Shared widths, register map and the divider cell payload type.
package ppp_pkg;

  localparam int unsigned PW = 65;
  localparam int unsigned HW = 51;
  localparam int unsigned NW = 63;
  localparam int unsigned DW = 51;
  localparam int unsigned QW = 33;
  localparam int unsigned FRAC_SH = 12;
  localparam int unsigned AW = 6;

  localparam logic [2:0] REG_MAT_00_01  = 3'd0;
  localparam logic [2:0] REG_MAT_02_10  = 3'd1;
  localparam logic [2:0] REG_MAT_11_12  = 3'd2;
  localparam logic [2:0] REG_MAT_20_21  = 3'd3;
  localparam logic [2:0] REG_MAT_22     = 3'd4;
  localparam logic [2:0] REG_CAM_POS_XY = 3'd5;
  localparam logic [2:0] REG_CAM_POS_Z  = 3'd6;
  localparam logic [2:0] NUM_REGS       = 3'd7;

  typedef struct packed {
    logic          vld;
    logic [NW-1:0] rem_x;
    logic [NW-1:0] rem_y;
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
    logic [DW-1:0] den;
    logic          neg_x;
    logic          neg_y;
    logic          zero_x;
    logic          zero_y;
    logic          big_x;
    logic          big_y;
    logic          den_zero;
    logic          behind;
  } div_t;

endpackage

[hdl/pinhole_point_projection_core.sv]
// Top level of the pinhole point projection core: register file, datapath, output stage.
//
// Usage
//   Configure the projection matrix and camera position over the APB port
//   (64-bit registers at byte address 8*i; mat_22 and cam_pos_z use the low
//   32 bits). Write configuration only while no request is in flight.
//   A request (one world point) is taken at each rising edge with start
//   high; busy stays low, so a new point may be issued every cycle.
//   Each result appears on pixel_x_o, pixel_y_o, behind_camera_o and
//   overflow_o for exactly one cycle, flagged by valid_o. Throughput is one point per cycle.
//   The pipeline is four offset/multiply/sum/set-up stages, a row of 33
//   divider cells (one quotient bit per cell, both rows share one
//   denominator) and the output register.
//   The receiver cannot stall; results are never held back.
//   Reset clears the configuration registers and the valid flags, which empties the pipeline.
module pinhole_point_projection_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ppp_pkg::AW-1:0] paddr,
  input  logic [63:0]            pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [31:0]     point_x_i,
  input  logic signed [31:0]     point_y_i,
  input  logic signed [31:0]     point_z_i,
  output logic                   valid_o,
  output logic signed [31:0]     pixel_x_o,
  output logic signed [31:0]     pixel_y_o,
  output logic                   behind_camera_o,
  output logic                   overflow_o
);
  import ppp_pkg::*;

  logic [63:0]      reg_q [7];
  logic [2:0]       idx;
  logic [8:0][31:0] mat;
  logic [2:0][31:0] cam;
  logic [2:0][31:0] pt;
  div_t             chain [QW+1];
  div_t             last;
  logic [31:0]      px_d, py_d;
  logic             ovx, ovy;
  logic             vld_q;
  logic [31:0]      px_q, py_q;
  logic             bh_q, ov_q;

  assign idx    = paddr[AW-1:3];
  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = (idx < NUM_REGS) ? reg_q[idx] : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) begin
        reg_q[i] <= 64'd0;
      end
    end else if (psel && penable && pwrite && (idx < NUM_REGS)) begin
      if (idx == REG_MAT_22 || idx == REG_CAM_POS_Z) begin
        reg_q[idx] <= {32'd0, pwdata[31:0]};
      end else begin
        reg_q[idx] <= pwdata;
      end
    end
  end

  assign mat = {reg_q[REG_MAT_22][31:0],
                reg_q[REG_MAT_20_21][31:0], reg_q[REG_MAT_20_21][63:32],
                reg_q[REG_MAT_11_12][31:0], reg_q[REG_MAT_11_12][63:32],
                reg_q[REG_MAT_02_10][31:0], reg_q[REG_MAT_02_10][63:32],
                reg_q[REG_MAT_00_01][31:0], reg_q[REG_MAT_00_01][63:32]};
  assign cam = {reg_q[REG_CAM_POS_Z][31:0], reg_q[REG_CAM_POS_XY][31:0],
                reg_q[REG_CAM_POS_XY][63:32]};
  assign pt  = {point_z_i, point_y_i, point_x_i};

  ppp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start),
    .mat_i  (mat),
    .cam_i  (cam),
    .pt_i   (pt),
    .div_o  (chain[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_cell
    ppp_div_cell #(.SHIFT(QW-1-k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  assign last = chain[QW];

  function automatic logic [32:0] sat_pix(input logic den_zero, input logic zero,
                                          input logic hneg, input logic behind,
                                          input logic big, input logic [QW-1:0] q);
    logic        rneg;
    logic [32:0] res;
    rneg = hneg ^ behind;
    if (den_zero) begin
      res = zero ? {1'b1, 32'd0} : (hneg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7fff_ffff});
    end else if (rneg) begin
      if (big || q > QW'(33'h1_0000_0000 >> 1)) begin
        res = {1'b1, 32'h8000_0000};
      end else begin
        res = {1'b0, 32'(-q)};
      end
    end else begin
      if (big || q > QW'(32'h7fff_ffff)) begin
        res = {1'b1, 32'h7fff_ffff};
      end else begin
        res = {1'b0, q[31:0]};
      end
    end
    return res;
  endfunction

  always_comb begin
    {ovx, px_d} = sat_pix(last.den_zero, last.zero_x, last.neg_x, last.behind,
                          last.big_x, last.q_x);
    {ovy, py_d} = sat_pix(last.den_zero, last.zero_y, last.neg_y, last.behind,
                          last.big_y, last.q_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
    bh_q <= last.behind;
    ov_q <= ovx | ovy;
  end

  assign valid_o         = vld_q;
  assign pixel_x_o       = px_q;
  assign pixel_y_o       = py_q;
  assign behind_camera_o = bh_q;
  assign overflow_o      = ov_q;

endmodule

[hdl/ppp_div_cell.sv]
// One restoring-division cell: resolves one quotient bit of both pixel rows.
module ppp_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ppp_pkg::div_t cell_i,
  output ppp_pkg::div_t cell_o
);
  import ppp_pkg::*;

  logic [DW+QW-1:0] dsh;
  logic             fit_x;
  logic             fit_y;
  div_t             cell_d;
  div_t             cell_q;

  always_comb begin
    dsh   = {{QW{1'b0}}, cell_i.den} << SHIFT;
    fit_x = {{(DW+QW-NW){1'b0}}, cell_i.rem_x} >= dsh;
    fit_y = {{(DW+QW-NW){1'b0}}, cell_i.rem_y} >= dsh;
    cell_d = cell_i;
    cell_d.rem_x = fit_x ? cell_i.rem_x - dsh[NW-1:0] : cell_i.rem_x;
    cell_d.rem_y = fit_y ? cell_i.rem_y - dsh[NW-1:0] : cell_i.rem_y;
    cell_d.q_x[SHIFT] = fit_x;
    cell_d.q_y[SHIFT] = fit_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.vld <= 1'b0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

[hdl/ppp_mac.sv]
// Offset, matrix multiply, rounding and row sums; prepares the divider operands.
module ppp_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  logic [8:0][31:0]    mat_i,
  input  logic [2:0][31:0]    cam_i,
  input  logic [2:0][31:0]    pt_i,
  output ppp_pkg::div_t       div_o
);
  import ppp_pkg::*;

  logic                  vld0_q, vld1_q, vld2_q;
  logic signed [32:0]    d_q [3];
  logic signed [PW-1:0]  p_q [9];
  logic signed [HW-1:0]  h_q [3];
  logic signed [PW-1:0]  pr [9];
  logic signed [HW-1:0]  h_d [3];
  logic [HW-1:0]         mag_x, mag_y, mag_z;
  div_t                  div_d;
  div_t                  div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld0_q <= vld_i;
      vld1_q <= vld0_q;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d_q[i] <= $signed({pt_i[i][31], pt_i[i]}) - $signed({cam_i[i][31], cam_i[i]});
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_q[3*r+c] <= PW'($signed(mat_i[3*r+c])) * PW'(d_q[c]);
      end
    end
    for (int r = 0; r < 3; r++) begin
      h_q[r] <= h_d[r];
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pr[i] = p_q[i] + PW'(32768);
    end
    for (int r = 0; r < 3; r++) begin
      h_d[r] = HW'($signed(pr[3*r][PW-1:16])) + HW'($signed(pr[3*r+1][PW-1:16]))
             + HW'($signed(pr[3*r+2][PW-1:16]));
    end
  end

  always_comb begin
    mag_x = h_q[0][HW-1] ? HW'(-h_q[0]) : HW'(h_q[0]);
    mag_y = h_q[1][HW-1] ? HW'(-h_q[1]) : HW'(h_q[1]);
    mag_z = h_q[2][HW-1] ? HW'(-h_q[2]) : HW'(h_q[2]);
    div_d.vld      = vld2_q;
    div_d.rem_x    = {mag_x, {FRAC_SH{1'b0}}};
    div_d.rem_y    = {mag_y, {FRAC_SH{1'b0}}};
    div_d.q_x      = '0;
    div_d.q_y      = '0;
    div_d.den      = mag_z;
    div_d.neg_x    = h_q[0][HW-1];
    div_d.neg_y    = h_q[1][HW-1];
    div_d.zero_x   = (h_q[0] == '0);
    div_d.zero_y   = (h_q[1] == '0);
    div_d.big_x    = {{(DW+QW-NW){1'b0}}, div_d.rem_x} >= {mag_z, {QW{1'b0}}};
    div_d.big_y    = {{(DW+QW-NW){1'b0}}, div_d.rem_y} >= {mag_z, {QW{1'b0}}};
    div_d.den_zero = (h_q[2] == '0);
    div_d.behind   = h_q[2][HW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q.vld <= 1'b0;
    end else begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

[verif/ppp_checker.sv]
// Checker for the pinhole point projection core: predicts each pixel result and compares.
module ppp_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic                   pready,
  input  logic [ppp_pkg::AW-1:0] paddr,
  input  logic [63:0]            pwdata,
  input  logic                   start,
  input  logic                   busy,
  input  logic signed [31:0]     point_x_i,
  input  logic signed [31:0]     point_y_i,
  input  logic signed [31:0]     point_z_i,
  input  logic                   valid_o,
  input  logic signed [31:0]     pixel_x_o,
  input  logic signed [31:0]     pixel_y_o,
  input  logic                   behind_camera_o,
  input  logic                   overflow_o,
  output int                     fail_count_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ppp_pkg::*;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               behind;
    logic               ovf;
  } pixel_t;

  logic [63:0] cfg_q [7];
  pixel_t      pixel_q [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = pixel_q.size();

  function automatic logic signed [63:0] lo_s(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic signed [63:0] hi_s(logic [63:0] v);
    return {{32{v[63]}}, v[63:32]};
  endfunction

  // floor((p + 2^15) / 2^16)
  function automatic logic signed [63:0] rnd_q16(logic signed [63:0] p);
    logic signed [63:0] a;
    a = p + 64'sd32768;
    return a >>> 16;
  endfunction

  function automatic logic signed [31:0] div_sat(logic signed [63:0] h,
      logic signed [63:0] dep, inout logic ovf);
    logic signed [63:0] q;
    if (dep == 0) begin
      ovf = 1'b1;
      if (h > 0) return 32'sh7fffffff;
      if (h < 0) return 32'sh80000000;
      return 0;
    end
    q = (h * 64'sd4096) / dep;
    if (q > 64'sh7fffffff) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -64'sh80000000) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic pixel_t project(logic signed [31:0] x, logic signed [31:0] y,
      logic signed [31:0] z);
    logic signed [63:0] dx, dy, dz, h0, h1, h2;
    logic               ovf;
    pixel_t             r;
    dx = 64'(x) - hi_s(cfg_q[REG_CAM_POS_XY]);
    dy = 64'(y) - lo_s(cfg_q[REG_CAM_POS_XY]);
    dz = 64'(z) - lo_s(cfg_q[REG_CAM_POS_Z]);
    h0 = rnd_q16(hi_s(cfg_q[REG_MAT_00_01]) * dx) + rnd_q16(lo_s(cfg_q[REG_MAT_00_01]) * dy)
       + rnd_q16(hi_s(cfg_q[REG_MAT_02_10]) * dz);
    h1 = rnd_q16(lo_s(cfg_q[REG_MAT_02_10]) * dx) + rnd_q16(hi_s(cfg_q[REG_MAT_11_12]) * dy)
       + rnd_q16(lo_s(cfg_q[REG_MAT_11_12]) * dz);
    h2 = rnd_q16(hi_s(cfg_q[REG_MAT_20_21]) * dx) + rnd_q16(lo_s(cfg_q[REG_MAT_20_21]) * dy)
       + rnd_q16(lo_s(cfg_q[REG_MAT_22]) * dz);
    ovf = 1'b0;
    r.px = div_sat(h0, h2, ovf);
    r.py = div_sat(h1, h2, ovf);
    r.behind = h2 < 0;
    r.ovf = ovf;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t e;
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) cfg_q[i] = '0;
      pixel_q.delete();
      fails = 0;
    end else begin
      if (valid_o) begin
        if (pixel_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result x=%0d y=%0d", $time, pixel_x_o, pixel_y_o);
        end else begin
          e = pixel_q.pop_front();
          if (e.px !== pixel_x_o) begin
            fails++;
            $display("%0t: pixel_x exp %0d got %0d", $time, e.px, pixel_x_o);
          end
          if (e.py !== pixel_y_o) begin
            fails++;
            $display("%0t: pixel_y exp %0d got %0d", $time, e.py, pixel_y_o);
          end
          if (e.behind !== behind_camera_o) begin
            fails++;
            $display("%0t: behind exp %0b got %0b", $time, e.behind, behind_camera_o);
          end
          if (e.ovf !== overflow_o) begin
            fails++;
            $display("%0t: overflow exp %0b got %0b", $time, e.ovf, overflow_o);
          end
        end
      end
      if (start && !busy) pixel_q.push_back(project(point_x_i, point_y_i, point_z_i));
      if (psel && penable && pwrite && pready && (paddr >> 3) < NUM_REGS) begin
        cfg_q[paddr >> 3] = ((paddr >> 3) == REG_MAT_22 || (paddr >> 3) == REG_CAM_POS_Z)
                          ? {32'h0, pwdata[31:0]} : pwdata;
      end
    end
  end
endmodule

[verif/testbench.sv]
// Testbench top for the pinhole point projection core: stimulus, configuration and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ppp_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0]        paddr = '0;
  logic [63:0]          pwdata = '0;
  logic [63:0]          prdata;
  logic                 pready, start = 1'b0, busy, valid_o, behind_camera_o, overflow_o;
  logic signed [31:0]   point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic signed [31:0]   pixel_x_o, pixel_y_o;
  int                   fail_count, pending;

  always #1 clk_i = ~clk_i;

  pinhole_point_projection_core u_dut (.*);
  ppp_checker u_chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hffffffff;
      3: return 32'($signed($urandom_range(0, 40'h20000)) - 32'sh10000);
      default: return $urandom();
    endcase
  endfunction

  // mostly a small coefficient, typical of a real camera matrix; one draw in four is any rnd32() value
  function automatic logic [31:0] coef();
    return $urandom_range(0, 3) == 0 ? rnd32()
         : 32'($signed($urandom_range(0, 32'h01000000)) - 32'sh00800000);
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = AW'(idx) << 3; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    start = 1'b1; point_x_i = x; point_y_i = y; point_z_i = z;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (45) @(negedge clk_i);
  endtask

  task automatic load_matrix(int mode);
    logic [63:0] v [7];
    for (int i = 0; i < 7; i++) begin
      case (mode)
        0: v[i] = '0;
        1: v[i] = 64'h7fffffff_7fffffff;
        2: v[i] = 64'h80000000_80000000;
        3: v[i] = 64'hffffffff_ffffffff;
        default: v[i] = {coef(), coef()};
      endcase
    end
    if (mode >= 4) begin
      v[REG_MAT_22] = {$urandom(), coef()};
      v[REG_CAM_POS_XY] = {rnd32(), rnd32()};
      v[REG_CAM_POS_Z] = {$urandom(), rnd32()};
    end
    for (int i = 0; i < 7; i++) reg_write(3'(i), v[i]);
  endtask

  initial begin
    int gap, burst, sent;
    logic [31:0] ext [4];
    ext = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero matrix: zero depth everywhere
    send_point(32'h12345678, 32'h0, 32'h0);
    start = 1'b0;
    drain();
    // extreme matrices against extreme points, plus an out-of-range address
    for (int m = 1; m <= 3; m++) begin
      load_matrix(m);
      reg_write(3'(NUM_REGS), '1);
      for (int k = 0; k < 6; k++)
        send_point(ext[k % 4], ext[(k + 1) % 4], ext[(k + 2) % 4]);
      start = 1'b0;
      drain();
    end

    sent = 0;
    for (int phase = 0; phase < 10; phase++) begin
      load_matrix(4);
      while (sent < (phase + 1) * 155) begin
        burst = $urandom_range(1, 30);
        for (int b = 0; b < burst; b++) begin
          send_point(rnd32(), rnd32(), rnd32());
          sent++;
        end
        gap = phase % 3 == 0 ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
          start = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      start = 1'b0;
      drain();
    end

    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #200000;
    $display("Some tests failed");
    $finish;
  end
endmodule
